/* src/fpa_pkg.sv */
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int WORD_W = 32;
	localparam int NUM_W = WORD_W + FRAC_BITS;
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES = WORD_W / DIV_BITS_PER_STAGE;

	localparam logic [WORD_W-1:0] S_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] S_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
		OP_MAX = 4'd12, OP_MIN = 4'd13, OP_TO_INT = 4'd14, OP_NONE = 4'd15
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SAT = 2'd1,
		ST_DIVZERO = 2'd2
	} status_t;

	// one item in flight
	typedef struct packed {
		opcode_t           op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic              neg;
		logic [2*WORD_W-1:0] prod;
		logic [WORD_W-1:0] den;
		logic [WORD_W-1:0] rem;
		logic [WORD_W-1:0] numsh;
		logic [WORD_W-1:0] quo;
		logic              dovf;
		logic              dzero;
	} pipe_t;

endpackage

/* src/fpa_div_step.sv */
module fpa_div_step (
	input  fpa_pkg::pipe_t din,
	output fpa_pkg::pipe_t dout
);
	import fpa_pkg::*;

	always_comb begin
		logic [WORD_W:0] t;
		dout = din;
		for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
			t = {dout.rem, dout.numsh[WORD_W-1]};
			dout.numsh = {dout.numsh[WORD_W-2:0], 1'b0};
			if (t >= {1'b0, dout.den}) begin
				dout.rem = WORD_W'(t - {1'b0, dout.den});
				dout.quo = {dout.quo[WORD_W-2:0], 1'b1};
			end else begin
				dout.rem = t[WORD_W-1:0];
				dout.quo = {dout.quo[WORD_W-2:0], 1'b0};
			end
		end
	end

endmodule

/* src/fpa_final.sv */
module fpa_final (
	input  fpa_pkg::pipe_t            din,
	output logic [fpa_pkg::WORD_W-1:0] result,
	output logic                      flag,
	output fpa_pkg::status_t          status
);
	import fpa_pkg::*;

	logic signed [WORD_W-1:0] sa, sb;
	logic [WORD_W:0] sum;
	logic [2*WORD_W-1:0] mq;
	logic [WORD_W:0] qr;
	logic over;

	assign sa = din.a;
	assign sb = din.b;

	always_comb begin
		result = '0;
		flag = 1'b0;
		status = ST_OK;
		sum = '0;
		mq = '0;
		qr = '0;
		over = 1'b0;
		unique case (din.op) inside
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				unique case (din.op)
					OP_ADD: sum = {din.a[WORD_W-1], din.a} + {din.b[WORD_W-1], din.b};
					OP_SUB: sum = {din.a[WORD_W-1], din.a} - {din.b[WORD_W-1], din.b};
					OP_INC: sum = {din.a[WORD_W-1], din.a} + (WORD_W+1)'(1);
					default: sum = {din.a[WORD_W-1], din.a} - (WORD_W+1)'(1);
				endcase
				if (sum[WORD_W] != sum[WORD_W-1]) begin
					status = ST_SAT;
					result = sum[WORD_W] ? S_MIN : S_MAX;
				end else begin
					result = sum[WORD_W-1:0];
				end
			end
			OP_MUL: begin
				mq = (din.prod + ((2*WORD_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
				over = din.neg ? (mq > (2*WORD_W)'({1'b0, S_MIN}))
				               : (mq > (2*WORD_W)'(S_MAX));
				if (over) begin
					status = ST_SAT;
					result = din.neg ? S_MIN : S_MAX;
				end else begin
					result = din.neg ? WORD_W'(-mq) : mq[WORD_W-1:0];
				end
			end
			OP_DIV: begin
				// round half up on the magnitude: compare twice the remainder with the divisor
				qr = {1'b0, din.quo} + (WORD_W+1)'({din.rem, 1'b0} >= {1'b0, din.den});
				over = din.dovf || (din.neg ? (qr > {1'b0, S_MIN}) : (qr > {1'b0, S_MAX}));
				if (din.dzero) begin
					status = ST_DIVZERO;
				end else if (over) begin
					status = ST_SAT;
					result = din.neg ? S_MIN : S_MAX;
				end else begin
					result = din.neg ? WORD_W'(-qr) : qr[WORD_W-1:0];
				end
			end
			OP_GT: flag = sa > sb;
			OP_LT: flag = sa < sb;
			OP_GE: flag = sa >= sb;
			OP_LE: flag = sa <= sb;
			OP_EQ: flag = sa == sb;
			OP_NE: flag = sa != sb;
			OP_MAX: result = (sa > sb) ? din.a : din.b;
			OP_MIN: result = (sa < sb) ? din.a : din.b;
			OP_TO_INT: result = WORD_W'(sa >>> FRAC_BITS);
			default: ;
		endcase
	end

endmodule

/* src/fixed_point_alu.sv */
// Fixed-point ALU on raw 32-bit words with FRAC_BITS fractional bits.
// Input stream: s_tuser carries the opcode, s_tdata the two operands.
// Output stream: m_tdata carries result, comparison flag and status.
// One result leaves for every input transfer, in order.
// Pipeline: 10 register stages (one prepare stage with the 32x32 magnitude
// multiplier, eight divider stages of four restoring quotient bits each,
// one rescale/saturate stage into the output register). Every opcode takes
// the same path. Throughput: one item per cycle while the receiver does not
// stall. The divider stages set the depth.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the block is ready right after reset.
// Status: 0 ok, 1 saturated, 2 division by zero (result 0).
module fixed_point_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // operand_a[31:0], operand_b[63:32], zero pad
	input  logic [3:0]  s_tuser,  // opcode[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // result[31:0], flag[32], status[34:33], zero pad
);
	import fpa_pkg::*;

	logic en;
	pipe_t prep;
	logic [WORD_W-1:0] amag, bmag;
	logic [NUM_W-1:0] num;

	pipe_t pipe_s [DIV_STAGES+1];
	logic [DIV_STAGES:0] valid_s;
	pipe_t step_out [DIV_STAGES];

	logic [WORD_W-1:0] fin_result;
	logic fin_flag;
	status_t fin_status;
	logic [WORD_W-1:0] result_q;
	logic flag_q;
	status_t status_q;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		prep.op = opcode_t'(s_tuser);
		prep.a = s_tdata[WORD_W-1:0];
		prep.b = s_tdata[2*WORD_W-1:WORD_W];
		amag = prep.a[WORD_W-1] ? WORD_W'(-prep.a) : prep.a;
		bmag = prep.b[WORD_W-1] ? WORD_W'(-prep.b) : prep.b;
		num = {amag, {FRAC_BITS{1'b0}}};
		prep.neg = prep.a[WORD_W-1] ^ prep.b[WORD_W-1];
		prep.prod = amag * bmag;
		prep.den = bmag;
		prep.rem = WORD_W'(num[NUM_W-1:WORD_W]);
		prep.numsh = num[WORD_W-1:0];
		prep.quo = '0;
		// quotient needs more than 32 bits when the high part reaches the divisor
		prep.dovf = WORD_W'(num[NUM_W-1:WORD_W]) >= bmag;
		prep.dzero = bmag == '0;
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		fpa_div_step u_step (
			.din  (pipe_s[g]),
			.dout (step_out[g])
		);
	end

	fpa_final u_final (
		.din    (pipe_s[DIV_STAGES]),
		.result (fin_result),
		.flag   (fin_flag),
		.status (fin_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			valid_s <= {valid_s[DIV_STAGES-1:0], s_tvalid};
			m_tvalid <= valid_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0] <= prep;
			for (int i = 0; i < DIV_STAGES; i++) pipe_s[i+1] <= step_out[i];
			result_q <= fin_result;
			flag_q <= fin_flag;
			status_q <= fin_status;
		end
	end

	assign m_tdata = {5'b0, status_q, flag_q, result_q};

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_q == ST_DIVZERO |-> result_q == '0 && !flag_q)
		else $error("division by zero with nonzero result");

	a_flag_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && flag_q |-> result_q == '0 && status_q == ST_OK)
		else $error("comparison flag with result or status");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_q == ST_SAT |-> result_q == S_MAX || result_q == S_MIN)
		else $error("saturated result not at a limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(valid_s))
		else $error("pipeline moved during stall");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import fpa_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [1:0]  status;
		logic        flag;
		logic [31:0] result;
	} alu_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	alu_out_t expected_results[$];
	int       error_count;
	int       idle_cycles;
	bit       quiet_mode;

	fixed_point_alu u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint clamp_word(input longint v, inout logic [1:0] st);
		if (v > 64'sd2147483647) begin
			st = ST_SAT;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			st = ST_SAT;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// round |num|/den to nearest, halves away from zero, then apply sign
	function automatic longint round_quotient(input logic [63:0] num, input logic [63:0] den,
			input bit neg);
		logic [63:0] q;
		q = (2 * num + den) / (2 * den);
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic alu_out_t compute_alu(input opcode_t op, input logic [31:0] ra,
			input logic [31:0] rb);
		longint      a;
		longint      b;
		longint      r;
		logic [63:0] ma;
		logic [63:0] mb;
		bit          neg;
		alu_out_t    o;
		a = longint'(signed'(ra));
		b = longint'(signed'(rb));
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		neg = (a < 0) != (b < 0);
		r = 0;
		o = '0;
		case (op)
			OP_ADD: r = clamp_word(a + b, o.status);
			OP_SUB: r = clamp_word(a - b, o.status);
			OP_MUL: r = clamp_word(round_quotient(ma * mb, 64'd1 << FRAC_BITS, neg), o.status);
			OP_DIV: begin
				if (b == 0) o.status = ST_DIVZERO;
				else r = clamp_word(round_quotient(ma << FRAC_BITS, mb, neg), o.status);
			end
			OP_GT: o.flag = a > b;
			OP_LT: o.flag = a < b;
			OP_GE: o.flag = a >= b;
			OP_LE: o.flag = a <= b;
			OP_EQ: o.flag = a == b;
			OP_NE: o.flag = a != b;
			OP_INC: r = clamp_word(a + 1, o.status);
			OP_DEC: r = clamp_word(a - 1, o.status);
			OP_MAX: r = a > b ? a : b;
			OP_MIN: r = a < b ? a : b;
			OP_TO_INT: r = a >>> FRAC_BITS;
			default: r = 0;
		endcase
		o.result = r[31:0];
		return o;
	endfunction

	// drive one transfer, sometimes with a random gap first (never in quiet mode)
	task automatic send_op(input opcode_t op, input logic [31:0] a, input logic [31:0] b);
		if (!quiet_mode && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {8'd0, b, a};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(compute_alu(op, a, b));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			4: return 32'h1;
			5: return 32'(signed'($urandom_range(0, 2048)) - 1024);
			6: return 32'h100;
			7: return 32'hffff_ff00;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_op(OP_ADD, 32'h7fff_ffff, 32'h1);
		send_op(OP_ADD, 32'h8000_0000, 32'hffff_ffff);
		send_op(OP_SUB, 32'h8000_0000, 32'h1);
		send_op(OP_SUB, 32'h7fff_ffff, 32'h8000_0000);
		send_op(OP_MUL, 32'h180, 32'h100);
		send_op(OP_MUL, 32'hffff_ffff, 32'h80);
		send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		send_op(OP_MUL, 32'h7fff_ffff, 32'hffff_ff00);
		send_op(OP_DIV, 32'h100, 32'h0);
		send_op(OP_DIV, 32'h100, 32'h300);
		send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_op(OP_DIV, 32'hffff_ffff, 32'h200);
		send_op(OP_GT, 32'h8000_0000, 32'h7fff_ffff);
		send_op(OP_LT, 32'h8000_0000, 32'h7fff_ffff);
		send_op(OP_GE, 32'h5, 32'h5);
		send_op(OP_LE, 32'h5, 32'h4);
		send_op(OP_EQ, 32'hffff_ffff, 32'hffff_ffff);
		send_op(OP_NE, 32'hffff_ffff, 32'hffff_ffff);
		send_op(OP_INC, 32'h7fff_ffff, $urandom);
		send_op(OP_DEC, 32'h8000_0000, $urandom);
		send_op(OP_MAX, 32'h1234, 32'h1234);
		send_op(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
		send_op(OP_TO_INT, 32'hffff_ff01, $urandom);
		send_op(OP_TO_INT, 32'h7fff_ffff, $urandom);
		send_op(OP_NONE, $urandom, $urandom);
	endtask

	task automatic test_random(input int count);
		logic [31:0] a;
		logic [31:0] b;
		for (int i = 0; i < count; i++) begin
			a = $urandom_range(0, 1) ? edge_value() : $urandom;
			b = $urandom_range(0, 1) ? edge_value() : $urandom;
			send_op(opcode_t'($urandom_range(0, 15)), a, b);
		end
	endtask

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		alu_out_t got;
		alu_out_t exp_out;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[34:0];
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer %h", m_tdata);
				error_count++;
			end else begin
				exp_out = expected_results.pop_front();
				if (got.result !== exp_out.result) begin
					$error("result: expected %h, actual %h", exp_out.result, got.result);
					error_count++;
				end
				if (got.flag !== exp_out.flag) begin
					$error("flag: expected %b, actual %b", exp_out.flag, got.flag);
					error_count++;
				end
				if (got.status !== exp_out.status) begin
					$error("status: expected %0d, actual %0d", exp_out.status, got.status);
					error_count++;
				end
			end
			if (m_tdata[39:35] !== '0) begin
				$error("pad: expected 0, actual %h", m_tdata[39:35]);
				error_count++;
			end
		end
	end

	// receiver stalls in bursts outside quiet mode
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet_mode || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4) - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_ADD;
		error_count = 0;
		idle_cycles = 0;
		quiet_mode = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		wait_drained();
		test_random(1400);
		quiet_mode = 1'b1;
		test_random(330);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/fpa_pkg.sv
src/fpa_div_step.sv
src/fpa_final.sv
src/fixed_point_alu.sv
verif/testbench.sv
